[rtl/core/sirn_pkg.sv]
package sirn_pkg;

    // field and datapath widths
    localparam int FIELD_W    = 48;
    localparam int HALF_W     = 24;
    localparam int N_FIELDS   = 12;
    localparam int OUT_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int SQ_W       = 96;
    localparam int SUM_W      = 97;
    localparam int DEN_W      = 97;
    localparam int CHUNK_W    = 32;
    localparam int TAU_CHUNKS = 4;
    localparam int OP_W       = CHUNK_W * TAU_CHUNKS;
    localparam int PP_W       = 2 * CHUNK_W;
    localparam int PROD_W     = OP_W + CHUNK_W;
    localparam int NUM_EXTRA  = 130;
    localparam int QUO_BITS   = 64;
    localparam int ROOT_BITS  = 32;
    localparam int SQ_REM_W   = 34;
    localparam int FRONT_STAGES = 11;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_SQUARED    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_FLOOR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_FRAME = 8'd2;

    localparam logic [CFG_W-1:0] TAU_SQUARED_RST    = 32'd16777216;
    localparam logic [CFG_W-1:0] ENERGY_FLOOR_RST   = 32'd168;
    localparam logic [CFG_W-1:0] CELLS_IN_FRAME_RST = 32'd1;

    // positions of the cell fields in the internal field array
    localparam int FLD_E      = 0;
    localparam int FLD_P      = 1;
    localparam int FLD_TT     = 2;
    localparam int FLD_TX     = 3;
    localparam int FLD_TY     = 4;
    localparam int FLD_TETA   = 5;
    localparam int FLD_XX     = 6;
    localparam int FLD_XY     = 7;
    localparam int FLD_XETA   = 8;
    localparam int FLD_YY     = 9;
    localparam int FLD_YETA   = 10;
    localparam int FLD_ETAETA = 11;

    typedef struct packed {
        logic signed [FIELD_W-1:0] energy_density;
        logic signed [FIELD_W-1:0] pressure;
        logic signed [FIELD_W-1:0] shear_tt;
        logic signed [FIELD_W-1:0] shear_tx;
        logic signed [FIELD_W-1:0] shear_ty;
        logic signed [FIELD_W-1:0] shear_teta;
        logic signed [FIELD_W-1:0] shear_xx;
        logic signed [FIELD_W-1:0] shear_xy;
        logic signed [FIELD_W-1:0] shear_xeta;
        logic signed [FIELD_W-1:0] shear_yy;
        logic signed [FIELD_W-1:0] shear_yeta;
        logic signed [FIELD_W-1:0] shear_etaeta;
    } cell_t;

    typedef struct packed {
        logic [OUT_W-1:0] inverse_reynolds;
        logic             saturated;
        logic             frame_done;
    } result_t;

    typedef struct packed {
        logic valid;
        logic sat;
        logic frame_done;
    } ctl_t;

endpackage

[rtl/core/sirn_front.sv]
module sirn_front
    import sirn_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  ctl_t                                   in_ctl,
    input  cell_t                                  cell_in,
    input  logic [CFG_W-1:0]                       tau_squared,
    input  logic [CFG_W-1:0]                       energy_floor,
    output ctl_t                                   out_ctl,
    output logic [2*FRAC_BITS+NUM_EXTRA-1:0]       num,
    output logic [DEN_W-1:0]                       den
);

    localparam int NUM_W = 2 * FRAC_BITS + NUM_EXTRA;
    localparam int HI_W  = NUM_W - QUO_BITS;

    logic [FIELD_W-1:0] fld [N_FIELDS];

    assign fld[FLD_E]      = cell_in.energy_density;
    assign fld[FLD_P]      = cell_in.pressure;
    assign fld[FLD_TT]     = cell_in.shear_tt;
    assign fld[FLD_TX]     = cell_in.shear_tx;
    assign fld[FLD_TY]     = cell_in.shear_ty;
    assign fld[FLD_TETA]   = cell_in.shear_teta;
    assign fld[FLD_XX]     = cell_in.shear_xx;
    assign fld[FLD_XY]     = cell_in.shear_xy;
    assign fld[FLD_XETA]   = cell_in.shear_xeta;
    assign fld[FLD_YY]     = cell_in.shear_yy;
    assign fld[FLD_YETA]   = cell_in.shear_yeta;
    assign fld[FLD_ETAETA] = cell_in.shear_etaeta;

    ctl_t ctl_reg [1:FRONT_STAGES];

    // stage 1: magnitudes and floor test
    logic [FIELD_W-1:0] s1_mag_next [N_FIELDS];
    logic [FIELD_W-1:0] s1_mag_reg  [N_FIELDS];
    logic               s1_low_next, s1_low_reg;

    // stage 2: 24 by 24 partial products of each square
    logic [FIELD_W-1:0] s2_ll_next [N_FIELDS];
    logic [FIELD_W-1:0] s2_hl_next [N_FIELDS];
    logic [FIELD_W-1:0] s2_hh_next [N_FIELDS];
    logic [FIELD_W-1:0] s2_ll_reg  [N_FIELDS];
    logic [FIELD_W-1:0] s2_hl_reg  [N_FIELDS];
    logic [FIELD_W-1:0] s2_hh_reg  [N_FIELDS];
    logic               s2_low_reg;

    // stage 3: squares
    logic [SQ_W-1:0] s3_sq_next [N_FIELDS];
    logic [SQ_W-1:0] s3_sq_reg  [N_FIELDS];
    logic            s3_low_reg;

    // stage 4: grouped sums and denominator
    logic [SUM_W-1:0] s4_pa_next, s4_na_next, s4_pb_next, s4_nb_next, s4_c_next;
    logic [SUM_W-1:0] s4_pa_reg, s4_na_reg, s4_pb_reg, s4_nb_reg, s4_c_reg;
    logic [DEN_W-1:0] s4_dsq, s4_den_next, s4_den_reg;

    // stage 5: tau squared partial products
    logic [OP_W-1:0] s5_pb_op, s5_nb_op, s5_c_op;
    logic [PP_W-1:0] s5_pbpp_next [TAU_CHUNKS];
    logic [PP_W-1:0] s5_nbpp_next [TAU_CHUNKS];
    logic [PP_W-1:0] s5_cpp_next  [TAU_CHUNKS];
    logic [PP_W-1:0] s5_pbpp_reg  [TAU_CHUNKS];
    logic [PP_W-1:0] s5_nbpp_reg  [TAU_CHUNKS];
    logic [PP_W-1:0] s5_cpp_reg   [TAU_CHUNKS];
    logic [SUM_W-1:0] s5_pa_reg, s5_na_reg;
    logic [DEN_W-1:0] s5_den_reg;

    // stage 6: tau squared products
    logic [PROD_W-1:0] s6_pb_next, s6_nb_next, s6_c_next;
    logic [PROD_W-1:0] s6_pb_reg, s6_nb_reg, s6_c_reg;
    logic [SUM_W-1:0]  s6_pa_reg, s6_na_reg;
    logic [DEN_W-1:0]  s6_den_reg;

    // stage 7: second tau squared partial products for the eta-eta term
    logic [OP_W-1:0]   s7_c_op;
    logic [PP_W-1:0]   s7_cpp_next [TAU_CHUNKS];
    logic [PP_W-1:0]   s7_cpp_reg  [TAU_CHUNKS];
    logic [PROD_W-1:0] s7_pb_reg, s7_nb_reg;
    logic [SUM_W-1:0]  s7_pa_reg, s7_na_reg;
    logic [DEN_W-1:0]  s7_den_reg;

    // stage 8
    logic [PROD_W-1:0] s8_c2_next, s8_c2_reg;
    logic [PROD_W-1:0] s8_pb_reg, s8_nb_reg;
    logic [SUM_W-1:0]  s8_pa_reg, s8_na_reg;
    logic [DEN_W-1:0]  s8_den_reg;

    // stage 9: positive and negative parts at 4F fraction bits
    logic [NUM_W-1:0] s9_pos_next, s9_neg_next, s9_pos_reg, s9_neg_reg;
    logic [DEN_W-1:0] s9_den_reg;

    // stage 10: magnitude of the numerator
    logic [NUM_W-1:0] s10_num_next, s10_num_reg;
    logic [DEN_W-1:0] s10_den_reg;

    // stage 11: overflow test
    logic             s11_sat_next;
    logic [NUM_W-1:0] s11_num_reg;
    logic [DEN_W-1:0] s11_den_reg;

    always_comb
    begin
        for (int i = 0; i < N_FIELDS; i++)
        begin
            s1_mag_next[i] = fld[i][FIELD_W-1] ? FIELD_W'(~fld[i] + 1'b1) : fld[i];
        end
        // any negative energy counts as below the floor
        s1_low_next = fld[FLD_E][FIELD_W-1] || (fld[FLD_E] < FIELD_W'(energy_floor));
    end

    always_comb
    begin
        for (int i = 0; i < N_FIELDS; i++)
        begin
            s2_ll_next[i] = FIELD_W'(s1_mag_reg[i][HALF_W-1:0])
                          * FIELD_W'(s1_mag_reg[i][HALF_W-1:0]);
            s2_hl_next[i] = FIELD_W'(s1_mag_reg[i][FIELD_W-1:HALF_W])
                          * FIELD_W'(s1_mag_reg[i][HALF_W-1:0]);
            s2_hh_next[i] = FIELD_W'(s1_mag_reg[i][FIELD_W-1:HALF_W])
                          * FIELD_W'(s1_mag_reg[i][FIELD_W-1:HALF_W]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < N_FIELDS; i++)
        begin
            s3_sq_next[i] = (SQ_W'(s2_hh_reg[i]) << FIELD_W)
                          + (SQ_W'(s2_hl_reg[i]) << (HALF_W + 1))
                          + SQ_W'(s2_ll_reg[i]);
        end
    end

    always_comb
    begin
        s4_pa_next = SUM_W'(s3_sq_reg[FLD_TT]) + SUM_W'(s3_sq_reg[FLD_XX])
                   + SUM_W'(s3_sq_reg[FLD_YY]) + (SUM_W'(s3_sq_reg[FLD_XY]) << 1);
        s4_na_next = (SUM_W'(s3_sq_reg[FLD_TX]) + SUM_W'(s3_sq_reg[FLD_TY])) << 1;
        s4_pb_next = (SUM_W'(s3_sq_reg[FLD_XETA]) + SUM_W'(s3_sq_reg[FLD_YETA])) << 1;
        s4_nb_next = SUM_W'(s3_sq_reg[FLD_TETA]) << 1;
        s4_c_next  = SUM_W'(s3_sq_reg[FLD_ETAETA]);
        s4_dsq     = DEN_W'(s3_sq_reg[FLD_E]) + DEN_W'(s3_sq_reg[FLD_P])
                   + (DEN_W'(s3_sq_reg[FLD_P]) << 1);
        s4_den_next = s3_low_reg ? (DEN_W'(energy_floor) << FRAC_BITS) : s4_dsq;
    end

    always_comb
    begin
        s5_pb_op = OP_W'(s4_pb_reg);
        s5_nb_op = OP_W'(s4_nb_reg);
        s5_c_op  = OP_W'(s4_c_reg);
        for (int j = 0; j < TAU_CHUNKS; j++)
        begin
            s5_pbpp_next[j] = PP_W'(s5_pb_op[j*CHUNK_W +: CHUNK_W]) * PP_W'(tau_squared);
            s5_nbpp_next[j] = PP_W'(s5_nb_op[j*CHUNK_W +: CHUNK_W]) * PP_W'(tau_squared);
            s5_cpp_next[j]  = PP_W'(s5_c_op[j*CHUNK_W +: CHUNK_W]) * PP_W'(tau_squared);
        end
    end

    always_comb
    begin
        s6_pb_next = '0;
        s6_nb_next = '0;
        s6_c_next  = '0;
        for (int j = 0; j < TAU_CHUNKS; j++)
        begin
            s6_pb_next = s6_pb_next + (PROD_W'(s5_pbpp_reg[j]) << (j * CHUNK_W));
            s6_nb_next = s6_nb_next + (PROD_W'(s5_nbpp_reg[j]) << (j * CHUNK_W));
            s6_c_next  = s6_c_next  + (PROD_W'(s5_cpp_reg[j])  << (j * CHUNK_W));
        end
    end

    // eta-eta times tau squared stays below 2^127
    always_comb
    begin
        s7_c_op = s6_c_reg[OP_W-1:0];
        for (int j = 0; j < TAU_CHUNKS; j++)
        begin
            s7_cpp_next[j] = PP_W'(s7_c_op[j*CHUNK_W +: CHUNK_W]) * PP_W'(tau_squared);
        end
    end

    always_comb
    begin
        s8_c2_next = '0;
        for (int j = 0; j < TAU_CHUNKS; j++)
        begin
            s8_c2_next = s8_c2_next + (PROD_W'(s7_cpp_reg[j]) << (j * CHUNK_W));
        end
    end

    always_comb
    begin
        s9_pos_next = (NUM_W'(s8_pa_reg) << (2 * FRAC_BITS))
                    + (NUM_W'(s8_pb_reg) << FRAC_BITS)
                    + NUM_W'(s8_c2_reg);
        s9_neg_next = (NUM_W'(s8_na_reg) << (2 * FRAC_BITS))
                    + (NUM_W'(s8_nb_reg) << FRAC_BITS);
    end

    always_comb
    begin
        if (s9_pos_reg >= s9_neg_reg)
        begin
            s10_num_next = s9_pos_reg - s9_neg_reg;
        end
        else
        begin
            s10_num_next = s9_neg_reg - s9_pos_reg;
        end
    end

    // quotient of 2^64 or more, or nothing to divide by
    assign s11_sat_next = (s10_den_reg == '0)
                       || (s10_num_reg[NUM_W-1:QUO_BITS] >= HI_W'(s10_den_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= FRONT_STAGES; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[1] <= in_ctl;
            for (int k = 2; k < FRONT_STAGES; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            ctl_reg[FRONT_STAGES] <= '{valid:      ctl_reg[FRONT_STAGES-1].valid,
                                       sat:        s11_sat_next,
                                       frame_done: ctl_reg[FRONT_STAGES-1].frame_done};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg <= s1_mag_next;
            s1_low_reg <= s1_low_next;

            s2_ll_reg  <= s2_ll_next;
            s2_hl_reg  <= s2_hl_next;
            s2_hh_reg  <= s2_hh_next;
            s2_low_reg <= s1_low_reg;

            s3_sq_reg  <= s3_sq_next;
            s3_low_reg <= s2_low_reg;

            s4_pa_reg  <= s4_pa_next;
            s4_na_reg  <= s4_na_next;
            s4_pb_reg  <= s4_pb_next;
            s4_nb_reg  <= s4_nb_next;
            s4_c_reg   <= s4_c_next;
            s4_den_reg <= s4_den_next;

            s5_pbpp_reg <= s5_pbpp_next;
            s5_nbpp_reg <= s5_nbpp_next;
            s5_cpp_reg  <= s5_cpp_next;
            s5_pa_reg   <= s4_pa_reg;
            s5_na_reg   <= s4_na_reg;
            s5_den_reg  <= s4_den_reg;

            s6_pb_reg  <= s6_pb_next;
            s6_nb_reg  <= s6_nb_next;
            s6_c_reg   <= s6_c_next;
            s6_pa_reg  <= s5_pa_reg;
            s6_na_reg  <= s5_na_reg;
            s6_den_reg <= s5_den_reg;

            s7_cpp_reg <= s7_cpp_next;
            s7_pb_reg  <= s6_pb_reg;
            s7_nb_reg  <= s6_nb_reg;
            s7_pa_reg  <= s6_pa_reg;
            s7_na_reg  <= s6_na_reg;
            s7_den_reg <= s6_den_reg;

            s8_c2_reg  <= s8_c2_next;
            s8_pb_reg  <= s7_pb_reg;
            s8_nb_reg  <= s7_nb_reg;
            s8_pa_reg  <= s7_pa_reg;
            s8_na_reg  <= s7_na_reg;
            s8_den_reg <= s7_den_reg;

            s9_pos_reg <= s9_pos_next;
            s9_neg_reg <= s9_neg_next;
            s9_den_reg <= s8_den_reg;

            s10_num_reg <= s10_num_next;
            s10_den_reg <= s9_den_reg;

            s11_num_reg <= s10_num_reg;
            s11_den_reg <= s10_den_reg;
        end
    end

    assign out_ctl = ctl_reg[FRONT_STAGES];
    assign num     = s11_num_reg;
    assign den     = s11_den_reg;

endmodule

[rtl/core/sirn_div_cell.sv]
module sirn_div_cell
    import sirn_pkg::*;
#(
    parameter int NUM_W = 178
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ctl_t                in_ctl,
    input  logic [NUM_W-1:0]    in_rem,
    input  logic [DEN_W-1:0]    in_den,
    input  logic [QUO_BITS-1:0] in_quo,
    output ctl_t                out_ctl,
    output logic [NUM_W-1:0]    out_rem,
    output logic [DEN_W-1:0]    out_den,
    output logic [QUO_BITS-1:0] out_quo
);

    // remainder is kept shifted so the divisor always lines up at the same place
    localparam int HI_W = NUM_W - QUO_BITS + 1;

    logic [HI_W-1:0]     hi;
    logic                ge;
    logic [HI_W-1:0]     hi_left;
    logic [NUM_W-1:0]    rem_next;
    logic [QUO_BITS-1:0] quo_next;

    ctl_t                ctl_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [QUO_BITS-1:0] quo_reg;

    always_comb
    begin
        hi       = in_rem[NUM_W-1:QUO_BITS-1];
        ge       = hi >= HI_W'(in_den);
        hi_left  = ge ? (hi - HI_W'(in_den)) : hi;
        rem_next = {hi_left, in_rem[QUO_BITS-2:0]} << 1;
        quo_next = {in_quo[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            quo_reg <= quo_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_rem = rem_reg;
    assign out_den = den_reg;
    assign out_quo = quo_reg;

endmodule

[rtl/core/sirn_sqrt_cell.sv]
module sirn_sqrt_cell
    import sirn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  ctl_t                 in_ctl,
    input  logic [QUO_BITS-1:0]  in_x,
    input  logic [SQ_REM_W-1:0]  in_rem,
    input  logic [ROOT_BITS-1:0] in_root,
    output ctl_t                 out_ctl,
    output logic [QUO_BITS-1:0]  out_x,
    output logic [SQ_REM_W-1:0]  out_rem,
    output logic [ROOT_BITS-1:0] out_root
);

    localparam int TRY_W = SQ_REM_W + 2;

    logic [TRY_W-1:0]     r;
    logic [TRY_W-1:0]     t;
    logic                 ge;
    logic [TRY_W-1:0]     r_left;

    ctl_t                 ctl_reg;
    logic [QUO_BITS-1:0]  x_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [ROOT_BITS-1:0] root_reg;

    // one root bit per cell, two radicand bits brought down
    always_comb
    begin
        r      = {in_rem, in_x[QUO_BITS-1:QUO_BITS-2]};
        t      = TRY_W'({in_root, 2'b01});
        ge     = r >= t;
        r_left = ge ? (r - t) : r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= in_x << 2;
            rem_reg  <= r_left[SQ_REM_W-1:0];
            root_reg <= {in_root[ROOT_BITS-2:0], ge};
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_x    = x_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;

endmodule

[rtl/core/shear_inverse_reynolds_unit.sv]
// Shear inverse Reynolds number, one grid cell per transfer. Each cell's
// metric-weighted sum of shear squares is divided by e^2 + 3p^2 (or by the
// energy floor) and the square root of the ratio is returned in unsigned
// fixed point, all ones with saturated set on overflow or a zero denominator.
// The datapath is a pipeline: eleven front stages of split multipliers and
// wide adds, a row of 64 divider cells (one quotient bit each), a row of 32
// square-root cells (one root bit each) and an output register. A cell is
// accepted every clock while the output is not held, so the sustained rate is
// one cell per cycle. The whole pipeline halts while a result waits under
// stall. No clearing pass is needed after reset.
module shear_inverse_reynolds_unit
    import sirn_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    output logic                 cell_stall,
    input  cell_t                cell_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NUM_W = 2 * FRAC_BITS + NUM_EXTRA;

    logic [CFG_W-1:0] tau_squared_reg, energy_floor_reg, cells_in_frame_reg;
    logic [CFG_W-1:0] cell_index_reg, cell_index_next;
    logic [CFG_W:0]   index_inc;
    logic             last_cell;
    logic             adv;
    logic             accept;
    ctl_t             in_ctl;

    ctl_t             front_ctl;
    logic [NUM_W-1:0] front_num;
    logic [DEN_W-1:0] front_den;

    ctl_t                d_ctl [QUO_BITS+1];
    logic [NUM_W-1:0]    d_rem [QUO_BITS+1];
    logic [DEN_W-1:0]    d_den [QUO_BITS+1];
    logic [QUO_BITS-1:0] d_quo [QUO_BITS+1];

    ctl_t                 q_ctl  [ROOT_BITS+1];
    logic [QUO_BITS-1:0]  q_x    [ROOT_BITS+1];
    logic [SQ_REM_W-1:0]  q_rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] q_root [ROOT_BITS+1];

    ctl_t             out_ctl_reg;
    logic [OUT_W-1:0] out_value_reg;

    // everything moves together unless a finished result is held
    assign adv        = !(out_ctl_reg.valid && result_stall);
    assign cell_stall = !adv;
    assign accept     = cell_valid && adv;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        index_inc       = {1'b0, cell_index_reg} + 1'b1;
        last_cell       = index_inc >= {1'b0, cells_in_frame_reg};
        cell_index_next = last_cell ? '0 : index_inc[CFG_W-1:0];
        in_ctl.valid      = cell_valid;
        in_ctl.sat        = 1'b0;
        in_ctl.frame_done = last_cell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_squared_reg    <= TAU_SQUARED_RST;
            energy_floor_reg   <= ENERGY_FLOOR_RST;
            cells_in_frame_reg <= CELLS_IN_FRAME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TAU_SQUARED:    tau_squared_reg    <= cfg_data;
                CFG_ENERGY_FLOOR:   energy_floor_reg   <= cfg_data;
                CFG_CELLS_IN_FRAME: cells_in_frame_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_index_reg <= '0;
        end
        else if (accept)
        begin
            cell_index_reg <= cell_index_next;
        end
    end

    sirn_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_ctl       (in_ctl),
        .cell_in      (cell_data),
        .tau_squared  (tau_squared_reg),
        .energy_floor (energy_floor_reg),
        .out_ctl      (front_ctl),
        .num          (front_num),
        .den          (front_den)
    );

    assign d_ctl[0] = front_ctl;
    assign d_rem[0] = front_num;
    assign d_den[0] = front_den;
    assign d_quo[0] = '0;

    for (genvar g = 0; g < QUO_BITS; g++)
    begin : g_div
        sirn_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_ctl  (d_ctl[g]),
            .in_rem  (d_rem[g]),
            .in_den  (d_den[g]),
            .in_quo  (d_quo[g]),
            .out_ctl (d_ctl[g+1]),
            .out_rem (d_rem[g+1]),
            .out_den (d_den[g+1]),
            .out_quo (d_quo[g+1])
        );
    end

    assign q_ctl[0]  = d_ctl[QUO_BITS];
    assign q_x[0]    = d_quo[QUO_BITS];
    assign q_rem[0]  = '0;
    assign q_root[0] = '0;

    for (genvar g = 0; g < ROOT_BITS; g++)
    begin : g_sqrt
        sirn_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_ctl   (q_ctl[g]),
            .in_x     (q_x[g]),
            .in_rem   (q_rem[g]),
            .in_root  (q_root[g]),
            .out_ctl  (q_ctl[g+1]),
            .out_x    (q_x[g+1]),
            .out_rem  (q_rem[g+1]),
            .out_root (q_root[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else if (adv)
        begin
            out_ctl_reg <= q_ctl[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_value_reg <= q_ctl[ROOT_BITS].sat ? '1 : q_root[ROOT_BITS];
        end
    end

    assign result_valid                 = out_ctl_reg.valid;
    assign result_data.inverse_reynolds = out_value_reg;
    assign result_data.saturated        = out_ctl_reg.sat;
    assign result_data.frame_done       = out_ctl_reg.frame_done;

endmodule

[rtl/core/sirn_checker.sv]
module sirn_checker
    import sirn_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    cell_valid,
    input logic    cell_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result_data
);

    // a held result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // saturation always reports full scale
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.saturated |-> result_data.inverse_reynolds == '1)
        else $error("saturated result not all ones");

    // input is only held back by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    // once the held result is taken the input opens again
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !result_stall |-> !cell_stall)
        else $error("input stalled with output free");

endmodule

bind shear_inverse_reynolds_unit sirn_checker u_sirn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

[bench/shear_inverse_reynolds_unit_tb.sv]
`timescale 1ns / 1ps

module shear_inverse_reynolds_unit_tb;
    import sirn_pkg::*;

    localparam int FRAC = 24;
    localparam int CYCLE_LIMIT = 600000;

    logic                 clk;
    logic                 rst_n;
    logic                 cell_valid;
    logic                 cell_stall;
    cell_t                cell_data;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    shear_inverse_reynolds_unit #(.FRAC_BITS(FRAC)) u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the register file and the frame counter
    logic [CFG_W-1:0] tau_sq_shadow;
    logic [CFG_W-1:0] floor_shadow;
    logic [CFG_W-1:0] frame_len_shadow;
    logic [31:0]      cell_count;

    cell_t   cells_pending[$];
    result_t results_due[$];

    int errors;
    int cells_sent;
    int results_seen;
    int saturated_seen;
    int frames_seen;
    int cycles;
    int send_gap;
    int stall_left;
    bit send_busy;
    bit recv_busy;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
        errors++;
    endtask

    function automatic logic [47:0] magnitude(input logic [47:0] v);
        if (v[47])
            return -v;
        return v;
    endfunction

    function automatic logic [255:0] square(input logic [47:0] v);
        logic [255:0] m;
        m = 256'(magnitude(v));
        return m * m;
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] q);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > q)
            b = b >> 2;
        while (b != 0)
        begin
            if (q >= r + b)
            begin
                q = q - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // inverse reynolds number of one cell, advances the frame counter
    function automatic result_t inverse_reynolds_of(input cell_t c);
        logic [255:0] tau;
        logic [255:0] plus_a;
        logic [255:0] minus_a;
        logic [255:0] plus_b;
        logic [255:0] minus_b;
        logic [255:0] quad;
        logic [255:0] num;
        logic [255:0] den;
        logic [255:0] quo;
        logic [32:0]  next;
        result_t      r;
        tau = 256'(tau_sq_shadow);
        plus_a = square(c.shear_tt) + square(c.shear_xx) + square(c.shear_yy)
               + 2 * square(c.shear_xy);
        minus_a = 2 * square(c.shear_tx) + 2 * square(c.shear_ty);
        plus_b = (2 * square(c.shear_xeta) + 2 * square(c.shear_yeta)) * tau;
        minus_b = 2 * square(c.shear_teta) * tau;
        quad = square(c.shear_etaeta) * tau * tau;
        plus_a = (plus_a << (2 * FRAC)) + (plus_b << FRAC) + quad;
        minus_a = (minus_a << (2 * FRAC)) + (minus_b << FRAC);
        num = (plus_a >= minus_a) ? plus_a - minus_a : minus_a - plus_a;
        if (c.energy_density[47] || {208'd0, c.energy_density} < {224'd0, floor_shadow})
            den = {224'd0, floor_shadow} << FRAC;
        else
            den = square(c.energy_density) + 3 * square(c.pressure);
        if (den == 0)
        begin
            r.inverse_reynolds = '1;
            r.saturated = 1'b1;
        end
        else
        begin
            quo = num / den;
            r.saturated = (quo[255:64] != 0);
            r.inverse_reynolds = r.saturated ? '1 : root64(quo[63:0]);
        end
        next = {1'b0, cell_count} + 33'd1;
        if (next >= {1'b0, frame_len_shadow})
        begin
            r.frame_done = 1'b1;
            cell_count = '0;
        end
        else
        begin
            r.frame_done = 1'b0;
            cell_count = next[31:0];
        end
        return r;
    endfunction

    // field value with a random scale, sign and the odd extreme
    function automatic logic [47:0] random_field();
        logic [63:0] raw;
        logic [47:0] v;
        int          k;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = 48'h7FFF_FFFF_FFFF;
            1: v = 48'h8000_0000_0000;
            2: v = '0;
            3, 4: v = raw[47:0];
            default:
            begin
                k = $urandom_range(1, 40);
                v = raw[47:0] >> (48 - k);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        c.energy_density = random_field();
        c.pressure       = random_field();
        c.shear_tt       = random_field();
        c.shear_tx       = random_field();
        c.shear_ty       = random_field();
        c.shear_teta     = random_field();
        c.shear_xx       = random_field();
        c.shear_xy       = random_field();
        c.shear_xeta     = random_field();
        c.shear_yy       = random_field();
        c.shear_yeta     = random_field();
        c.shear_etaeta   = random_field();
        // mostly a physical cell: energy well above shear so the root stays in range
        if ($urandom_range(0, 3) != 0)
            c.energy_density = (48'($urandom_range(1, 255)) << 32) >> $urandom_range(0, 8);
        return c;
    endfunction

    function automatic cell_t uniform_cell(input logic [47:0] v);
        cell_t c;
        c = {N_FIELDS{v}};
        return c;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TAU_SQUARED:    tau_sq_shadow    = val;
            CFG_ENERGY_FLOOR:   floor_shadow     = val;
            CFG_CELLS_IN_FRAME: frame_len_shadow = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (cells_pending.size() != 0 || cell_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n)
            cells_pending.push_back(random_cell());
    endtask

    // cell driver
    always @(posedge clk)
    begin
        cell_t c;
        bit    presenting;
        if (rst_n)
        begin
            presenting = cell_valid;
            if (cell_valid && !cell_stall)
            begin
                results_due.push_back(inverse_reynolds_of(cell_data));
                cells_sent++;
                presenting = 1'b0;
                send_gap = send_busy ? $urandom_range(0, 18) : 0;
                if ($urandom_range(0, 40) == 0)
                    send_busy = !send_busy;
            end
            if (!presenting)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cell_valid <= 1'b0;
                end
                else if (cells_pending.size() != 0)
                begin
                    c = cells_pending.pop_front();
                    cell_data  <= c;
                    cell_valid <= 1'b1;
                end
                else
                    cell_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("unexpected result transfer: %0h", result_data);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result_data.inverse_reynolds !== want.inverse_reynolds)
                        report_mismatch("inverse_reynolds",
                                        64'(result_data.inverse_reynolds),
                                        64'(want.inverse_reynolds));
                    if (result_data.saturated !== want.saturated)
                        report_mismatch("saturated", 64'(result_data.saturated),
                                        64'(want.saturated));
                    if (result_data.frame_done !== want.frame_done)
                        report_mismatch("frame_done", 64'(result_data.frame_done),
                                        64'(want.frame_done));
                    saturated_seen += want.saturated;
                    frames_seen += want.frame_done;
                end
                results_seen++;
                stall_left = recv_busy ? $urandom_range(0, 18) : 0;
                if ($urandom_range(0, 40) == 0)
                    recv_busy = !recv_busy;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        cell_t c;
        rst_n        = 1'b0;
        cell_valid   = 1'b0;
        cell_data    = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors = 0; cells_sent = 0; results_seen = 0; saturated_seen = 0;
        frames_seen = 0; cycles = 0; send_gap = 0; stall_left = 0;
        send_busy = 1'b1; recv_busy = 1'b1;
        tau_sq_shadow    = TAU_SQUARED_RST;
        floor_shadow     = ENERGY_FLOOR_RST;
        frame_len_shadow = CELLS_IN_FRAME_RST;
        cell_count       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells at reset settings
        cells_pending.push_back(uniform_cell('0));
        cells_pending.push_back(uniform_cell(48'h7FFF_FFFF_FFFF));
        cells_pending.push_back(uniform_cell(48'h8000_0000_0000));
        cells_pending.push_back(uniform_cell(48'hFFFF_FFFF_FFFF));
        cells_pending.push_back(uniform_cell(48'h0000_0100_0000));
        c = uniform_cell(48'h0000_0100_0000);
        c.energy_density = 48'hFFFF_FF00_0000;          // negative energy
        cells_pending.push_back(c);
        c.energy_density = 48'd167;                     // just under the floor
        cells_pending.push_back(c);
        c.energy_density = 48'd168;                     // at the floor
        cells_pending.push_back(c);
        c = uniform_cell('0);
        c.energy_density = 48'h0000_1000_0000;
        c.shear_tx = 48'h0000_0100_0000;                // negative contraction
        cells_pending.push_back(c);
        c.shear_tt = 48'h7FFF_FFFF_FFFF;                // saturating ratio
        cells_pending.push_back(c);
        c = uniform_cell('0);
        c.energy_density = 48'h7FFF_FFFF_FFFF;
        c.pressure = 48'h8000_0000_0000;
        c.shear_etaeta = 48'h7FFF_FFFF_FFFF;
        cells_pending.push_back(c);
        queue_random(8);
        wait_idle();

        // zero floor gives a zero denominator for zero energy and pressure
        write_register(CFG_TAU_SQUARED, 32'hFFFF_FFFF);
        write_register(CFG_ENERGY_FLOOR, 32'd0);
        write_register(CFG_CELLS_IN_FRAME, 32'd0);
        cells_pending.push_back(uniform_cell('0));
        c = uniform_cell(48'h0000_0100_0000);
        c.energy_density = 48'hFFFF_FFFF_FFFF;
        cells_pending.push_back(c);
        queue_random(200);
        wait_idle();

        write_register(CFG_TAU_SQUARED, 32'd0);
        write_register(CFG_ENERGY_FLOOR, 32'hFFFF_FFFF);
        write_register(CFG_CELLS_IN_FRAME, 32'd3);
        write_register(8'd3, $urandom);                 // unmapped, no effect
        write_register(8'd255, $urandom);
        queue_random(200);
        wait_idle();

        write_register(CFG_TAU_SQUARED, $urandom);
        write_register(CFG_ENERGY_FLOOR, $urandom_range(0, 4096));
        write_register(CFG_CELLS_IN_FRAME, 32'd7);
        queue_random(250);
        wait_idle();

        write_register(CFG_TAU_SQUARED, TAU_SQUARED_RST);
        write_register(CFG_ENERGY_FLOOR, ENERGY_FLOOR_RST);
        write_register(CFG_CELLS_IN_FRAME, 32'hFFFF_FFFF);
        queue_random(200);
        wait_idle();

        // frame length lowered below the running count
        write_register(CFG_CELLS_IN_FRAME, 32'd5);
        write_register(CFG_TAU_SQUARED, $urandom_range(1 << 20, 1 << 26));
        queue_random(200);
        wait_idle();

        repeat (120) @(posedge clk);
        $display("%0d cells over six register settings, %0d results checked", cells_sent,
                 results_seen);
        $display("%0d saturated results, %0d frame ends, %0d errors", saturated_seen,
                 frames_seen, errors);
        if (errors == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
